@@ src/ranging_timing_budget_encoder_assert.svh @@
// assertion macros used by the checker file
`ifndef RANGING_TIMING_BUDGET_ENCODER_ASSERT_SVH
`define RANGING_TIMING_BUDGET_ENCODER_ASSERT_SVH

// checked outside reset only
`define RTBE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define RTBE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ src/rtbe_pkg.sv @@
package rtbe_pkg;

  // budget limits and scaling constants
  localparam logic [31:0] OVERHEAD_US   = 32'd4528;
  localparam logic [31:0] MAX_RANGE_US  = 32'd1100000;
  localparam logic [31:0] PLL_DIVIDEND  = 32'h4000_0000;
  localparam logic [11:0] MACRO_SCALE   = 12'd2304;
  localparam logic [31:0] PHASECAL_US   = 32'd1000;
  localparam logic [7:0]  PHASECAL_MAX  = 8'hFF;
  localparam int          RANGE_W       = 20;
  localparam int          MACRO_W       = 26;
  localparam int          PLL_W         = 31;
  localparam int          DIV_W         = 32;
  localparam int          DIV_CNT_W     = $clog2(DIV_W);

  // register file
  localparam int          CFG_ADDR_W    = 2;
  localparam int          CFG_DATA_W    = 16;
  localparam logic [7:0]  VCSEL_A_RESET = 8'd15;
  localparam logic [7:0]  VCSEL_B_RESET = 8'd13;

  // stream widths
  localparam int          IN_TDATA_W    = 32;
  localparam int          OUT_FIELDS_W  = 74;
  localparam int          OUT_TDATA_W   = 80;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_OSC     = 2'd0,
    CFG_VCSEL_A = 2'd1,
    CFG_VCSEL_B = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_SMALL    = 2'd1,
    STAT_HIGH     = 2'd2,
    STAT_ZERO_DIV = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL,
    ST_DIV,
    ST_OUT
  } state_e;

  // micro-operations run in this order
  typedef enum logic [3:0] {
    OP_PLL,
    OP_MUL_A1,
    OP_MUL_A2,
    OP_MUL_B1,
    OP_MUL_B2,
    OP_PC,
    OP_MM_A,
    OP_RG_A,
    OP_MM_B,
    OP_RG_B
  } op_e;

  // exponent/mantissa packing of a 16-bit mclk count
  function automatic logic [15:0] encode_mclks(input logic [31:0] count);
    logic [15:0] v;
    logic [3:0]  e;
    logic [15:0] sh;
    v = count[15:0] - 16'd1;
    e = 4'd0;
    for (int i = 8; i < 16; i++) begin
      if (v[i]) begin
        e = 4'(i - 7);
      end
    end
    sh = v >> e;
    if (count[15:0] == 16'd0) begin
      return 16'd0;
    end
    return {4'd0, e, sh[7:0]};
  endfunction

endpackage

@@ src/ranging_timing_budget_encoder.sv @@
// Ranging timing budget encoder.
// Input stream s_axis: one transfer carries a 32-bit budget in microseconds.
// Output stream m_axis: one transfer per input with a status code and the
// phase-calibration timeout plus four encoded timeouts (all zero on failure).
// Config port: cfg_we_i/cfg_addr_i/cfg_wdata_i write the oscillator word
// (index 0) and the two VCSEL period codes (index 1 and 2).
// One item at a time: s_axis_tready is high only while the sequencer idles.
// The work per item is six 32-bit divisions on one restoring radix-2
// divider and four passes through one 32x12 multiplier.
// The result sits in an output register; a stalled receiver holds it there
// while the next item is already taken and worked on, and the sequencer
// waits only when a new result is ready before the old one was taken.
// Reset clears the sequencer and output valid and restores the register
// defaults (oscillator 0, period codes 15 and 13).
module ranging_timing_budget_encoder (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration writes
  input  logic                               cfg_we_i,
  input  logic [rtbe_pkg::CFG_ADDR_W-1:0]    cfg_addr_i,
  input  logic [rtbe_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  // input stream
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [rtbe_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // [31:0] budget
  // output stream
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [1:0] status, [9:2] phasecal_timeout, [25:10] mm_timeout_a,
  // [41:26] range_timeout_a, [57:42] mm_timeout_b, [73:58] range_timeout_b
  output logic [rtbe_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

  // control state
  rtbe_pkg::state_e                  state_q, state_d;
  rtbe_pkg::op_e                     op_q, op_d;
  logic [rtbe_pkg::DIV_CNT_W-1:0]    cnt_q, cnt_d;
  logic                              out_valid_q, out_valid_d;

  // configuration registers
  logic [15:0]                       osc_q;
  logic [7:0]                        vcsel_a_q, vcsel_b_q;

  // datapath registers
  rtbe_pkg::status_e                 status_q, status_d;
  logic [rtbe_pkg::RANGE_W-1:0]      range_q, range_d;
  logic [rtbe_pkg::PLL_W-1:0]        pll_q, pll_d;
  logic [rtbe_pkg::MACRO_W-1:0]      prod_q, prod_d;
  logic [rtbe_pkg::MACRO_W-1:0]      ma_q, ma_d;
  logic [rtbe_pkg::MACRO_W-1:0]      mb_q, mb_d;
  logic [rtbe_pkg::DIV_W-1:0]        rem_q, rem_d;
  logic [rtbe_pkg::DIV_W-1:0]        dq_q, dq_d;
  logic [rtbe_pkg::DIV_W-1:0]        dvs_q, dvs_d;
  logic [7:0]                        pc_q, pc_d;
  logic [15:0]                       mm_a_q, mm_a_d, rg_a_q, rg_a_d;
  logic [15:0]                       mm_b_q, mm_b_d;
  logic [rtbe_pkg::OUT_TDATA_W-1:0]  out_q, out_d;

  // shared unit signals
  logic [31:0]                       mul_a;
  logic [11:0]                       mul_b;
  logic [31:0]                       mul_p;
  logic [32:0]                       rem_sh;
  logic                              div_ge;
  logic [31:0]                       rem_next, dq_next;
  logic [7:0]                        pclks_a, pclks_b;
  logic [31:0]                       range_full;
  logic [rtbe_pkg::MACRO_W-1:0]      div_macro;
  logic [31:0]                       div_us_sh;
  logic                              in_xfer;

  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == rtbe_pkg::ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  // pclks = doubled successor of the period code, 8-bit wrap
  assign pclks_a = {vcsel_a_q[6:0] + 7'd1, 1'b0};
  assign pclks_b = {vcsel_b_q[6:0] + 7'd1, 1'b0};

  assign range_full = s_axis_tdata - rtbe_pkg::OVERHEAD_US;

  // shared multiplier operand select
  always_comb begin
    case (op_q)
      rtbe_pkg::OP_MUL_A2: begin
        mul_a = {6'd0, prod_q};
        mul_b = {4'd0, pclks_a};
      end
      rtbe_pkg::OP_MUL_B2: begin
        mul_a = {6'd0, prod_q};
        mul_b = {4'd0, pclks_b};
      end
      default: begin
        mul_a = {1'b0, pll_q};
        mul_b = rtbe_pkg::MACRO_SCALE;
      end
    endcase
  end

  assign mul_p = mul_a * {20'd0, mul_b};

  // restoring divider step
  assign rem_sh   = {rem_q, dq_q[31]};
  assign div_ge   = rem_sh >= {1'b0, dvs_q};
  assign rem_next = div_ge ? 32'(rem_sh - {1'b0, dvs_q}) : rem_sh[31:0];
  assign dq_next  = {dq_q[30:0], div_ge};

  // dividend and divisor for the timeout divisions
  always_comb begin
    case (op_q)
      rtbe_pkg::OP_PC: begin
        div_macro = ma_q;
        div_us_sh = 32'(rtbe_pkg::PHASECAL_US << 12);
      end
      rtbe_pkg::OP_MM_A: begin
        div_macro = ma_q;
        div_us_sh = 32'h0000_1000;
      end
      rtbe_pkg::OP_RG_A: begin
        div_macro = ma_q;
        div_us_sh = {range_q, 12'd0};
      end
      rtbe_pkg::OP_MM_B: begin
        div_macro = mb_q;
        div_us_sh = 32'h0000_1000;
      end
      default: begin
        div_macro = mb_q;
        div_us_sh = {range_q, 12'd0};
      end
    endcase
  end

  // sequencer and datapath next state
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    status_d    = status_q;
    range_d     = range_q;
    pll_d       = pll_q;
    prod_d      = prod_q;
    ma_d        = ma_q;
    mb_d        = mb_q;
    rem_d       = rem_q;
    dq_d        = dq_q;
    dvs_d       = dvs_q;
    pc_d        = pc_q;
    mm_a_d      = mm_a_q;
    rg_a_d      = rg_a_q;
    mm_b_d      = mm_b_q;
    out_d       = out_q;

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      rtbe_pkg::ST_IDLE: begin
        if (in_xfer) begin
          range_d = range_full[rtbe_pkg::RANGE_W:1];
          op_d    = rtbe_pkg::OP_PLL;
          if (s_axis_tdata <= rtbe_pkg::OVERHEAD_US) begin
            status_d = rtbe_pkg::STAT_SMALL;
            state_d  = rtbe_pkg::ST_OUT;
          end else if (range_full > rtbe_pkg::MAX_RANGE_US) begin
            status_d = rtbe_pkg::STAT_HIGH;
            state_d  = rtbe_pkg::ST_OUT;
          end else if (osc_q == 16'd0) begin
            status_d = rtbe_pkg::STAT_ZERO_DIV;
            state_d  = rtbe_pkg::ST_OUT;
          end else begin
            status_d = rtbe_pkg::STAT_OK;
            state_d  = rtbe_pkg::ST_LOAD;
          end
        end
      end

      // dispatch the current operation
      rtbe_pkg::ST_LOAD: begin
        cnt_d = rtbe_pkg::DIV_CNT_W'(rtbe_pkg::DIV_W - 1);
        rem_d = '0;
        case (op_q)
          rtbe_pkg::OP_PLL: begin
            dq_d    = rtbe_pkg::PLL_DIVIDEND;
            dvs_d   = {16'd0, osc_q};
            state_d = rtbe_pkg::ST_DIV;
          end
          rtbe_pkg::OP_MUL_A1, rtbe_pkg::OP_MUL_A2,
          rtbe_pkg::OP_MUL_B1, rtbe_pkg::OP_MUL_B2: begin
            state_d = rtbe_pkg::ST_MUL;
          end
          default: begin
            dq_d    = div_us_sh + {7'd0, div_macro[rtbe_pkg::MACRO_W-1:1]};
            dvs_d   = {6'd0, div_macro};
            state_d = rtbe_pkg::ST_DIV;
            if (op_q == rtbe_pkg::OP_PC && (ma_q == '0 || mb_q == '0)) begin
              status_d = rtbe_pkg::STAT_ZERO_DIV;
              state_d  = rtbe_pkg::ST_OUT;
            end
          end
        endcase
      end

      // one pass through the multiplier
      rtbe_pkg::ST_MUL: begin
        state_d = rtbe_pkg::ST_LOAD;
        case (op_q)
          rtbe_pkg::OP_MUL_A1: begin
            prod_d = mul_p[31:6];
            op_d   = rtbe_pkg::OP_MUL_A2;
          end
          rtbe_pkg::OP_MUL_A2: begin
            ma_d = mul_p[31:6];
            op_d = rtbe_pkg::OP_MUL_B1;
          end
          rtbe_pkg::OP_MUL_B1: begin
            prod_d = mul_p[31:6];
            op_d   = rtbe_pkg::OP_MUL_B2;
          end
          default: begin
            mb_d = mul_p[31:6];
            op_d = rtbe_pkg::OP_PC;
          end
        endcase
      end

      // one quotient bit a cycle
      rtbe_pkg::ST_DIV: begin
        rem_d = rem_next;
        dq_d  = dq_next;
        cnt_d = cnt_q - rtbe_pkg::DIV_CNT_W'(1);
        if (cnt_q == '0) begin
          state_d = rtbe_pkg::ST_LOAD;
          case (op_q)
            rtbe_pkg::OP_PLL: begin
              pll_d = dq_next[rtbe_pkg::PLL_W-1:0];
              op_d  = rtbe_pkg::OP_MUL_A1;
            end
            rtbe_pkg::OP_PC: begin
              pc_d = (dq_next > 32'(rtbe_pkg::PHASECAL_MAX)) ?
                     rtbe_pkg::PHASECAL_MAX : dq_next[7:0];
              op_d = rtbe_pkg::OP_MM_A;
            end
            rtbe_pkg::OP_MM_A: begin
              mm_a_d = rtbe_pkg::encode_mclks(dq_next);
              op_d   = rtbe_pkg::OP_RG_A;
            end
            rtbe_pkg::OP_RG_A: begin
              rg_a_d = rtbe_pkg::encode_mclks(dq_next);
              op_d   = rtbe_pkg::OP_MM_B;
            end
            rtbe_pkg::OP_MM_B: begin
              mm_b_d = rtbe_pkg::encode_mclks(dq_next);
              op_d   = rtbe_pkg::OP_RG_B;
            end
            default: begin
              state_d = rtbe_pkg::ST_OUT;
            end
          endcase
        end
      end

      // hand the result to the output register once it is free
      rtbe_pkg::ST_OUT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          state_d     = rtbe_pkg::ST_IDLE;
          if (status_q == rtbe_pkg::STAT_OK) begin
            out_d = {6'd0, rtbe_pkg::encode_mclks(dq_q), mm_b_q, rg_a_q, mm_a_q,
                     pc_q, status_q};
          end else begin
            out_d = {78'd0, status_q};
          end
        end
      end

      default: begin
        state_d = rtbe_pkg::ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rtbe_pkg::ST_IDLE;
      op_q        <= rtbe_pkg::OP_PLL;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      osc_q     <= 16'd0;
      vcsel_a_q <= rtbe_pkg::VCSEL_A_RESET;
      vcsel_b_q <= rtbe_pkg::VCSEL_B_RESET;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        rtbe_pkg::CFG_OSC:     osc_q     <= cfg_wdata_i;
        rtbe_pkg::CFG_VCSEL_A: vcsel_a_q <= cfg_wdata_i[7:0];
        rtbe_pkg::CFG_VCSEL_B: vcsel_b_q <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    range_q  <= range_d;
    pll_q    <= pll_d;
    prod_q   <= prod_d;
    ma_q     <= ma_d;
    mb_q     <= mb_d;
    rem_q    <= rem_d;
    dq_q     <= dq_d;
    dvs_q    <= dvs_d;
    pc_q     <= pc_d;
    mm_a_q   <= mm_a_d;
    rg_a_q   <= rg_a_d;
    mm_b_q   <= mm_b_d;
    out_q    <= out_d;
  end

endmodule

@@ src/rtbe_checker.sv @@
`include "ranging_timing_budget_encoder_assert.svh"

module rtbe_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               s_axis_tvalid,
  input logic                               s_axis_tready,
  input logic                               m_axis_tvalid,
  input logic                               m_axis_tready,
  input logic [rtbe_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

  // a held result must not change
  `RTBE_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "output changed while stalled")

  // one item at a time: busy right after an input transfer
  `RTBE_ASSERT(a_busy_after_in, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "input taken while busy")

  // a failed result carries zero timeouts and zero padding
  `RTBE_ASSERT(a_fail_zero, m_axis_tvalid && m_axis_tdata[1:0] != rtbe_pkg::STAT_OK |-> m_axis_tdata[rtbe_pkg::OUT_TDATA_W-1:2] == '0, "failed result has nonzero fields")

  // no result shown once reset has been seen
  `RTBE_ASSERT_ALWAYS(a_rst_quiet, !rst_ni |=> !m_axis_tvalid, "output valid during reset")

endmodule

bind ranging_timing_budget_encoder rtbe_checker u_rtbe_checker (.*);
